// ----- src/b64d_pkg.sv -----
package b64d_pkg;

  localparam logic [7:0] PadChar = 8'h3D;

  typedef enum logic [2:0] {
    ST_DATA       = 3'd0,
    ST_END_OK     = 3'd1,
    ST_BAD_CHAR   = 3'd2,
    ST_INCOMPLETE = 3'd3,
    ST_BAD_PAD    = 3'd4
  } status_t;

  // Results caused by one input item: up to three bytes of word, oldest in the high bits.
  typedef struct packed {
    logic [1:0]  cnt;
    status_t     status;
    logic [23:0] word;
  } bundle_t;

  // Returns {valid, sextet} for one character of the standard alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= 8'h41 && c <= 8'h5A) begin
        d = c - 8'h41;
        sextet_of = {1'b1, d[5:0]};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        d = c - 8'h61 + 8'd26;
        sextet_of = {1'b1, d[5:0]};
      end else if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30 + 8'd52;
        sextet_of = {1'b1, d[5:0]};
      end else if (c == 8'h2B) begin
        sextet_of = {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
        sextet_of = {1'b1, 6'd63};
      end else begin
        sextet_of = {1'b0, d[5:0]};
      end
    end
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    begin
      is_blank = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    end
  endfunction

endpackage

// ----- src/b64d_core.sv -----
module b64d_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [7:0]        in_char,
  input  logic              in_stream_end,
  input  logic              drop_garbage,
  output b64d_pkg::bundle_t res
);
  import b64d_pkg::*;

  logic [17:0] held_r, held_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [2:0]  pads_r, pads_nxt;
  logic        failed_r, failed_nxt;

  logic [6:0]  sx;
  logic        is_pad;
  logic [2:0]  pads_tot;
  logic [1:0]  nbytes;

  assign sx       = sextet_of(in_char);
  assign is_pad   = (in_char == PadChar);
  assign pads_tot = pads_r + {2'b00, is_pad};
  assign nbytes   = 2'd3 - pads_tot[1:0];

  always_comb begin
    held_nxt   = held_r;
    fill_nxt   = fill_r;
    pads_nxt   = pads_r;
    failed_nxt = failed_r;
    res.cnt    = 2'd0;
    res.status = ST_DATA;
    res.word   = 24'd0;
    if (in_stream_end) begin
      if (!failed_r) begin
        res.cnt    = 2'd1;
        res.status = (fill_r != 2'd0 && !drop_garbage) ? ST_INCOMPLETE : ST_END_OK;
      end
      held_nxt   = 18'd0;
      fill_nxt   = 2'd0;
      pads_nxt   = 3'd0;
      failed_nxt = 1'b0;
    end else if (failed_r || is_blank(in_char)) begin
      res.cnt = 2'd0;
    end else if (!is_pad && !sx[6]) begin
      if (!drop_garbage) begin
        failed_nxt = 1'b1;
        res.cnt    = 2'd1;
        res.status = ST_BAD_CHAR;
      end
    end else if (!is_pad && pads_r != 3'd0) begin
      // Data may not follow padding within a group.
      failed_nxt = 1'b1;
      res.cnt    = 2'd1;
      res.status = ST_BAD_PAD;
    end else if (fill_r != 2'd3) begin
      held_nxt = {held_r[11:0], is_pad ? 6'd0 : sx[5:0]};
      fill_nxt = fill_r + 2'd1;
      pads_nxt = pads_r + {2'b00, is_pad};
    end else begin
      held_nxt = 18'd0;
      fill_nxt = 2'd0;
      pads_nxt = 3'd0;
      if (pads_tot > 3'd2) begin
        failed_nxt = 1'b1;
        res.cnt    = 2'd1;
        res.status = ST_BAD_PAD;
      end else begin
        res.cnt  = nbytes;
        res.word = {held_r, is_pad ? 6'd0 : sx[5:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= 18'd0;
      fill_r   <= 2'd0;
      pads_r   <= 3'd0;
      failed_r <= 1'b0;
    end else if (load) begin
      held_r   <= held_nxt;
      fill_r   <= fill_nxt;
      pads_r   <= pads_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

// ----- src/base64_stream_decoder.sv -----
// Base64 text decoder, standard alphabet, one character per input item.
// Input channel (in_valid/in_ready): in_char, or in_stream_end = 1 to close the stream.
// Result channel (out_valid/out_ready): out_byte, out_status and out_last_of_run,
// which marks the final result that one input item causes.
// Configuration channel (cfg_valid/cfg_ready): cfg_drop_garbage, always ready; write it
// only while no item is in flight.
// An accepted item enters a two-entry queue; it is decoded from the queue head and its
// first result is registered in the output register once that register is free.
// Throughput is one character per cycle while the receiver does not stall. Items that
// give no result decode while earlier bytes drain; an item that gives results waits until
// the output register is sending its last result, so a completed group's three bytes go
// out one per cycle while the next group's first three characters are decoded.
// Whitespace, ignored garbage and the first three characters of a group give no result.
// Reset clears the queue, the output register, the group state and the register.
// When the receiver stalls, the output holds; items that give no result still pass,
// and in_ready drops once two items wait in the queue.
module base64_stream_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_stream_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [2:0] out_status,
  output logic       out_last_of_run,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_drop_garbage
);
  import b64d_pkg::*;

  logic       ig_r;

  // Two-entry input queue.
  logic [7:0] q_char_r [2];
  logic       q_end_r  [2];
  logic       q_wr_r, q_rd_r;
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic       push, load, pop;

  // Output register holding the results of one item.
  logic [7:0] bytes_r [3];
  status_t    status_r;
  logic [1:0] bcnt_r;
  bundle_t    res;

  assign cfg_ready = 1'b1;
  assign in_ready  = (q_cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  // Items that give no result never touch the output register.
  assign load      = (q_cnt_r != 2'd0) &&
                     ((bcnt_r == 2'd0) || (bcnt_r == 2'd1 && pop) || (res.cnt == 2'd0));
  assign q_cnt_nxt = q_cnt_r + {1'b0, push} - {1'b0, load};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ig_r <= 1'b0;
    end else if (cfg_valid) begin
      ig_r <= cfg_drop_garbage;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= 1'b0;
      q_rd_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) begin
        q_wr_r <= ~q_wr_r;
      end
      if (load) begin
        q_rd_r <= ~q_rd_r;
      end
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_char_r[q_wr_r] <= in_char;
      q_end_r[q_wr_r]  <= in_stream_end;
    end
  end

  b64d_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .in_char       (q_char_r[q_rd_r]),
    .in_stream_end (q_end_r[q_rd_r]),
    .drop_garbage  (ig_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= 2'd0;
    end else if (load && res.cnt != 2'd0) begin
      bcnt_r <= res.cnt;
    end else if (pop) begin
      bcnt_r <= bcnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.cnt != 2'd0) begin
      bytes_r[0] <= res.word[23:16];
      bytes_r[1] <= res.word[15:8];
      bytes_r[2] <= res.word[7:0];
      status_r   <= res.status;
    end else if (pop) begin
      bytes_r[0] <= bytes_r[1];
      bytes_r[1] <= bytes_r[2];
    end
  end

  assign out_valid       = (bcnt_r != 2'd0);
  assign out_byte        = bytes_r[0];
  assign out_status      = status_r;
  assign out_last_of_run = (bcnt_r == 2'd1);

  // Status results come alone, so each is the last of its item.
  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DATA |-> out_last_of_run)
    else $error("status result not marked last");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DATA |-> out_byte == 8'd0)
    else $error("status result carries a nonzero byte");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !out_last_of_run |=> out_valid && out_status == ST_DATA)
    else $error("byte run broken before its last result");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3 && !(load && q_cnt_r == 2'd0))
    else $error("input queue count out of range");

endmodule

// ----- dv/b64_decode_checker.sv -----
`timescale 1ns / 100ps

module b64_decode_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_stream_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic [2:0] out_status,
  input  logic       out_last_of_run,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_drop_garbage,
  output int         mismatches,
  output int         pending_results
);
  import b64d_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    status_t    status;
    logic       last;
  } decoded_byte_t;

  decoded_byte_t expected_results[$];
  decoded_byte_t oldest;

  // Decoder state as seen from the text stream.
  logic [17:0] held_sextets;
  int          group_fill;
  int          pads_held;
  logic        stream_failed;
  logic        drop_garbage;

  function automatic int sextet_code(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
    if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61 + 26;
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 52;
    if (c == 8'h2B) return 62;
    if (c == 8'h2F) return 63;
    return -1;
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  task automatic push_result(input logic [7:0] d, input status_t s, input logic l);
    decoded_byte_t r;
    r.data   = d;
    r.status = s;
    r.last   = l;
    expected_results.push_back(r);
  endtask

  task automatic clear_group();
    held_sextets = '0;
    group_fill   = 0;
    pads_held    = 0;
  endtask

  task automatic decode_item(input logic [7:0] c, input logic stream_end);
    int          v;
    bit          is_pad;
    int          pads;
    int          nbytes;
    logic [23:0] word;
    if (stream_end) begin
      if (!stream_failed) begin
        if (group_fill != 0 && !drop_garbage) begin
          push_result(8'h00, ST_INCOMPLETE, 1'b1);
        end else begin
          push_result(8'h00, ST_END_OK, 1'b1);
        end
      end
      clear_group();
      stream_failed = 1'b0;
      return;
    end
    if (stream_failed || blank_char(c)) return;
    is_pad = (c == PadChar);
    v = is_pad ? 0 : sextet_code(c);
    if (!is_pad && v < 0) begin
      if (!drop_garbage) begin
        stream_failed = 1'b1;
        push_result(8'h00, ST_BAD_CHAR, 1'b1);
      end
      return;
    end
    // Data may not follow a '=' inside one group.
    if (!is_pad && pads_held != 0) begin
      stream_failed = 1'b1;
      push_result(8'h00, ST_BAD_PAD, 1'b1);
      return;
    end
    if (group_fill < 3) begin
      held_sextets = {held_sextets[11:0], v[5:0]};
      group_fill++;
      if (is_pad) pads_held++;
      return;
    end
    word = {held_sextets, v[5:0]};
    pads = pads_held + (is_pad ? 1 : 0);
    clear_group();
    if (pads > 2) begin
      stream_failed = 1'b1;
      push_result(8'h00, ST_BAD_PAD, 1'b1);
      return;
    end
    nbytes = 3 - pads;
    for (int i = 0; i < nbytes; i++) begin
      push_result(word[23 - 8 * i -: 8], ST_DATA, i == nbytes - 1);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_group();
      stream_failed  = 1'b0;
      drop_garbage   = 1'b0;
      expected_results.delete();
      mismatches     = 0;
    end else begin
      // Results are checked before this edge's item is predicted, so a stray result
      // can never be matched against an expectation created in the same cycle.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: byte %02h status %0d last %0d", $time,
                   out_byte, out_status, out_last_of_run);
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          if (out_byte !== oldest.data || out_status !== oldest.status ||
              out_last_of_run !== oldest.last) begin
            $display("%0t: mismatch: expected byte %02h status %0d last %0d, got byte %02h status %0d last %0d",
                     $time, oldest.data, oldest.status, oldest.last,
                     out_byte, out_status, out_last_of_run);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) drop_garbage = cfg_drop_garbage;
      if (in_valid && in_ready) decode_item(in_char, in_stream_end);
    end
    pending_results = expected_results.size();
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import b64d_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int DrainCycles  = 8;
  localparam int ItemsPerPass = 28;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char = 8'h00;
  logic       in_stream_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] out_status;
  logic       out_last_of_run;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_drop_garbage = 1'b0;

  int   mismatches;
  int   pending_results;
  int   in_idle_pct = 0;
  int   out_stall_pct = 0;
  int   items_sent = 0;
  int   item_target = 0;
  int   cycle_count;
  logic garbage_ignored = 1'b0;

  base64_stream_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char          (in_char),
    .in_stream_end    (in_stream_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_status       (out_status),
    .out_last_of_run  (out_last_of_run),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_drop_garbage (cfg_drop_garbage)
  );

  b64_decode_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char          (in_char),
    .in_stream_end    (in_stream_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_status       (out_status),
    .out_last_of_run  (out_last_of_run),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_drop_garbage (cfg_drop_garbage),
    .mismatches       (mismatches),
    .pending_results  (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Whitespace, and noise characters while garbage is ignored, are sent with counted = 0.
  task automatic send_item(input logic [7:0] c, input logic stream_end, input bit counted);
    int gaps;
    gaps = 0;
    while (gaps < 20 && $urandom_range(99) < in_idle_pct) gaps++;
    @(negedge clk);
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_char       <= c;
    in_stream_end <= stream_end;
    do @(posedge clk); while (!in_ready);
    if (counted) items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0, 1'b1);
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(255)), 1'b1, 1'b1);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_config(input logic value);
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_drop_garbage <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    garbage_ignored = value;
  endtask

  function automatic logic [7:0] random_alpha();
    int idx;
    idx = $urandom_range(63);
    if (idx < 26) return 8'(8'h41 + idx);
    if (idx < 52) return 8'(8'h61 + idx - 26);
    if (idx < 62) return 8'(8'h30 + idx - 52);
    return (idx == 62) ? 8'h2B : 8'h2F;
  endfunction

  function automatic logic [7:0] random_blank();
    int k;
    k = $urandom_range(5);
    return (k == 0) ? 8'h20 : 8'(8'h08 + k);
  endfunction

  // One stream of whole groups, sometimes padded, sometimes with one slip in it.
  task automatic send_stream();
    logic [7:0] text[$];
    int         groups;
    int         pads;
    int         fault;
    int         pos;
    groups = $urandom_range(1, 4);
    for (int g = 0; g < 4 * groups; g++) text.push_back(random_alpha());
    pads = ($urandom_range(99) < 40) ? $urandom_range(1, 2) : 0;
    for (int k = 0; k < pads; k++) text[text.size() - 1 - k] = PadChar;
    fault = ($urandom_range(99) < 25) ? $urandom_range(1, 4) : 0;
    case (fault)
      1: begin
        repeat ($urandom_range(1, 3)) void'(text.pop_back());
      end
      2: begin
        pos = text.size() - 4 + $urandom_range(0, 2);
        text[pos] = PadChar;
      end
      3: begin
        pos = $urandom_range(3, 4);
        for (int k = 0; k < pos; k++) text[text.size() - 1 - k] = PadChar;
      end
      4: begin
        pos = $urandom_range(0, text.size() - 1);
        text.insert(pos, 8'($urandom_range(255)));
      end
      default: ;
    endcase
    foreach (text[i]) begin
      if ($urandom_range(99) < 10) send_item(random_blank(), 1'b0, 1'b0);
      send_item(text[i], 1'b0, 1'b1);
    end
    send_end();
  endtask

  task automatic send_noise();
    repeat ($urandom_range(3, 10)) send_item(8'($urandom_range(255)), 1'b0, !garbage_ignored);
    send_end();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with garbage reported as after reset.
    send_text("Zz");
    send_item(8'h20, 1'b0, 1'b0);
    send_item(8'h09, 1'b0, 1'b0);
    send_item(8'h0D, 1'b0, 1'b0);
    send_text("0/");
    send_text("AQ==");
    send_end();
    send_text("A=Ax");
    send_end();
    send_text("====");
    send_end();
    send_text("AB");
    send_end();
    send_item(8'hFF, 1'b0, 1'b1);
    send_end();
    drain();
    write_config(1'b1);
    send_item(8'h80, 1'b0, 1'b0);
    send_text("AB");
    send_end();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 74; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 74; end
        default: begin in_idle_pct = 18; out_stall_pct = 18; end
      endcase
      for (int pass = 0; pass < 2; pass++) begin
        drain();
        write_config(1'((phase + pass) % 2));
        item_target = items_sent + ItemsPerPass;
        while (items_sent < item_target) begin
          if ($urandom_range(99) < 12) send_noise();
          else send_stream();
        end
      end
    end

    drain();
    if (mismatches == 0 && pending_results == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- base64_stream_decoder.f -----
src/b64d_pkg.sv
src/b64d_core.sv
src/base64_stream_decoder.sv
dv/b64_decode_checker.sv
dv/testbench.sv
